[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is high
`define STRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// next-cycle implication built on the macro above
`define STRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  `STRS_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

[rtl/strs_pkg.sv]
// shared types, codes, constants and the test rom of the run sequencer
// no dependencies
package strs_pkg;

  localparam int NUM_TESTS      = 14;
  localparam int MAX_STEPS      = 15;
  localparam int ROM_LEN        = 14;
  localparam int TEST_W         = 4;
  localparam int STEP_W         = 4;
  localparam int TIMEOUT_W      = 16;
  localparam int PERMILLE_SCALE = 1000;
  localparam int PERMILLE_W     = 10;
  localparam int PROD_W         = 14;
  localparam int DIV_STEPS      = PROD_W;
  localparam int DIVCNT_W       = $clog2(DIV_STEPS + 1);
  localparam int IN_TDATA_W     = 120;
  localparam int OUT_TDATA_W    = 88;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_ABORT = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // action outcomes
  localparam logic [1:0] OC_FINISHED    = 2'd0;
  localparam logic [1:0] OC_PENDING     = 2'd1;
  localparam logic [1:0] OC_UNSUPPORTED = 2'd2;
  localparam logic [1:0] OC_ERROR       = 2'd3;

  // verdicts
  localparam logic [1:0] V_PASS  = 2'd0;
  localparam logic [1:0] V_FAIL  = 2'd1;
  localparam logic [1:0] V_SKIP  = 2'd2;
  localparam logic [1:0] V_ERROR = 2'd3;
  localparam logic [7:0] V_MAX_LEGAL = 8'd3;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ADVANCED    = 3'd1;
  localparam logic [2:0] ST_COMPLETE    = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_BUSY        = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_NOT_RUNNING = 3'd6;

  // event kinds
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_START    = 3'd1;
  localparam logic [2:0] EV_PROGRESS = 3'd2;
  localparam logic [2:0] EV_RESULT   = 3'd3;
  localparam logic [2:0] EV_ABORT    = 3'd4;

  typedef struct packed {
    logic [STEP_W-1:0]    steps;
    logic [TIMEOUT_W-1:0] timeout;
    logic                 deferred;
  } test_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_start;
    logic sel_second;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic two_results;
    logic div_busy;
  } dp_status_t;

  function automatic test_entry_t test_rom(input logic [TEST_W-1:0] idx);
    test_entry_t e;
    case (idx)
      4'd0:    e = '{steps: 4'd1, timeout: 16'd3000,  deferred: 1'b0};
      4'd1:    e = '{steps: 4'd9, timeout: 16'd1000,  deferred: 1'b0};
      4'd2:    e = '{steps: 4'd5, timeout: 16'd2000,  deferred: 1'b0};
      4'd3:    e = '{steps: 4'd5, timeout: 16'd4000,  deferred: 1'b0};
      4'd4:    e = '{steps: 4'd6, timeout: 16'd2000,  deferred: 1'b0};
      4'd5:    e = '{steps: 4'd4, timeout: 16'd15000, deferred: 1'b0};
      4'd6:    e = '{steps: 4'd4, timeout: 16'd3000,  deferred: 1'b0};
      4'd7:    e = '{steps: 4'd2, timeout: 16'd2000,  deferred: 1'b0};
      4'd8:    e = '{steps: 4'd3, timeout: 16'd3000,  deferred: 1'b0};
      4'd9:    e = '{steps: 4'd3, timeout: 16'd5000,  deferred: 1'b0};
      4'd10:   e = '{steps: 4'd1, timeout: 16'd3000,  deferred: 1'b1};
      4'd11:   e = '{steps: 4'd2, timeout: 16'd5000,  deferred: 1'b0};
      4'd12:   e = '{steps: 4'd1, timeout: 16'd5000,  deferred: 1'b0};
      4'd13:   e = '{steps: 4'd2, timeout: 16'd2000,  deferred: 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

  // severity order pass < skip < fail < error
  function automatic logic [1:0] rank(input logic [1:0] v);
    logic [1:0] r;
    case (v)
      V_PASS:  r = 2'd0;
      V_SKIP:  r = 2'd1;
      V_FAIL:  r = 2'd2;
      default: r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

[rtl/strs_div.sv]
// serial restoring divider, one quotient bit per cycle, for the permille figure
// depends on strs_pkg
module strs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [strs_pkg::PROD_W-1:0]    dividend,
  input  logic [strs_pkg::STEP_W-1:0]    divisor,
  output logic [strs_pkg::PERMILLE_W-1:0] quotient,
  output logic                           busy
);

  logic [strs_pkg::PROD_W-1:0]   quo;
  logic [strs_pkg::STEP_W-1:0]   rem;
  logic [strs_pkg::DIVCNT_W-1:0] cnt;
  logic [strs_pkg::STEP_W:0]     trial;
  logic                          ge;

  // remainder stays below the divisor, so the shifted trial fits one extra bit
  assign trial = {rem, quo[strs_pkg::PROD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= strs_pkg::DIVCNT_W'(strs_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - strs_pkg::DIVCNT_W'(1);
      if (cnt == strs_pkg::DIVCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? strs_pkg::STEP_W'(trial - {1'b0, divisor})
                : trial[strs_pkg::STEP_W-1:0];
      quo <= {quo[strs_pkg::PROD_W-2:0], ge};
    end
  end

  assign quotient = quo[strs_pkg::PERMILLE_W-1:0];

endmodule

[rtl/strs_datapath.sv]
// run state, command evaluation, result registers and the permille divider
// depends on strs_pkg and strs_div
module strs_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  strs_pkg::dp_cmd_t     ctl,
  output strs_pkg::dp_status_t  stat,
  input  logic [1:0]            cmd,
  input  logic [7:0]            test_id,
  input  logic [31:0]           session_id,
  input  logic [31:0]           now_ms,
  input  logic [1:0]            action_outcome,
  input  logic [7:0]            action_verdict,
  input  logic signed [31:0]    action_value,
  input  logic                  action_done,
  output logic [2:0]            status,
  output logic [2:0]            event_kind,
  output logic [3:0]            event_test,
  output logic [3:0]            event_step,
  output logic [1:0]            event_verdict,
  output logic signed [31:0]    event_value,
  output logic [31:0]           run_id,
  output logic                  busy_res,
  output logic [9:0]            progress_permille
);

  // latched request
  logic [1:0]  in_cmd;
  logic [7:0]  in_test_id;
  logic [31:0] in_session;
  logic [31:0] in_now;
  logic [1:0]  in_outcome;
  logic [7:0]  in_verdict;
  logic [31:0] in_value;
  logic        in_done;

  // run state
  logic                        running, running_next;
  logic [strs_pkg::TEST_W-1:0] current_test, current_test_next;
  logic [strs_pkg::STEP_W-1:0] step_index, step_index_next;
  logic [strs_pkg::STEP_W-1:0] step_total, step_total_next;
  logic [1:0]                  worst_verdict, worst_verdict_next;
  logic [3:0]                  failure_count, failure_count_next;
  logic [31:0]                 session_of_run, session_of_run_next;
  logic [31:0]                 step_start_time, step_start_time_next;
  logic [31:0]                 current_run_id, current_run_id_next;
  logic [31:0]                 next_run_number, next_run_number_next;

  // result registers
  logic [2:0]  res_status, res_status_next;
  logic [2:0]  r0_kind, r0_kind_next;
  logic [3:0]  r0_step, r0_step_next;
  logic [1:0]  r0_verdict, r0_verdict_next;
  logic [31:0] r0_value, r0_value_next;
  logic [3:0]  r1_step, r1_step_next;
  logic [1:0]  r1_verdict, r1_verdict_next;
  logic [31:0] r1_value, r1_value_next;
  logic        two, two_next;

  strs_pkg::test_entry_t        start_entry;
  strs_pkg::test_entry_t        cur_entry;
  logic [31:0]                  elapsed;
  logic [strs_pkg::STEP_W-1:0]  start_steps;
  logic [31:0]                  run_inc;
  logic                         rec;
  logic [1:0]                   rec_verdict;
  logic [31:0]                  rec_value;
  logic [strs_pkg::PERMILLE_W-1:0] quotient;
  logic                         div_busy;
  logic [strs_pkg::PROD_W-1:0]  dividend;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      in_cmd     <= cmd;
      in_test_id <= test_id;
      in_session <= session_id;
      in_now     <= now_ms;
      in_outcome <= action_outcome;
      in_verdict <= action_verdict;
      in_value   <= action_value;
      in_done    <= action_done;
    end
  end

  always_comb begin
    start_entry = strs_pkg::test_rom(in_test_id[strs_pkg::TEST_W-1:0]);
    cur_entry   = strs_pkg::test_rom(current_test);
    elapsed     = in_now - step_start_time;
    start_steps = (start_entry.steps == '0) ? strs_pkg::STEP_W'(1) : start_entry.steps;
    if (start_steps > strs_pkg::STEP_W'(strs_pkg::MAX_STEPS)) begin
      start_steps = strs_pkg::STEP_W'(strs_pkg::MAX_STEPS);
    end
    run_inc = next_run_number + 32'd1;

    running_next         = running;
    current_test_next    = current_test;
    step_index_next      = step_index;
    step_total_next      = step_total;
    worst_verdict_next   = worst_verdict;
    failure_count_next   = failure_count;
    session_of_run_next  = session_of_run;
    step_start_time_next = step_start_time;
    current_run_id_next  = current_run_id;
    next_run_number_next = next_run_number;

    res_status_next = strs_pkg::ST_OK;
    r0_kind_next    = strs_pkg::EV_NONE;
    r0_step_next    = '0;
    r0_verdict_next = strs_pkg::V_PASS;
    r0_value_next   = '0;
    r1_step_next    = '0;
    r1_verdict_next = strs_pkg::V_PASS;
    r1_value_next   = '0;
    two_next        = 1'b0;

    rec         = 1'b0;
    rec_verdict = strs_pkg::V_PASS;
    rec_value   = '0;

    case (in_cmd)
      strs_pkg::CMD_START: begin
        if (in_test_id >= 8'(strs_pkg::NUM_TESTS) || in_test_id >= 8'(strs_pkg::ROM_LEN)) begin
          res_status_next = strs_pkg::ST_INVALID;
        end else if (running) begin
          res_status_next = strs_pkg::ST_BUSY;
        end else if (start_entry.deferred) begin
          res_status_next = strs_pkg::ST_UNSUPPORTED;
        end else begin
          running_next         = 1'b1;
          current_test_next    = in_test_id[strs_pkg::TEST_W-1:0];
          step_index_next      = '0;
          step_total_next      = start_steps;
          worst_verdict_next   = strs_pkg::V_PASS;
          failure_count_next   = '0;
          session_of_run_next  = in_session;
          step_start_time_next = in_now;
          current_run_id_next  = next_run_number;
          // run ids skip zero on wrap
          next_run_number_next = (run_inc == '0) ? 32'd1 : run_inc;
          r0_kind_next         = strs_pkg::EV_START;
          r0_value_next        = 32'(start_steps);
        end
      end
      strs_pkg::CMD_STEP: begin
        if (running) begin
          case (in_outcome)
            strs_pkg::OC_PENDING: begin
              if (elapsed > 32'(cur_entry.timeout)) begin
                rec         = 1'b1;
                rec_verdict = strs_pkg::V_ERROR;
                rec_value   = elapsed;
              end
            end
            strs_pkg::OC_UNSUPPORTED: begin
              rec         = 1'b1;
              rec_verdict = strs_pkg::V_SKIP;
              rec_value   = in_value;
            end
            strs_pkg::OC_ERROR: begin
              rec         = 1'b1;
              rec_verdict = strs_pkg::V_ERROR;
              rec_value   = in_value;
            end
            default: begin
              rec         = 1'b1;
              rec_verdict = (in_verdict > strs_pkg::V_MAX_LEGAL) ? strs_pkg::V_ERROR
                                                                  : in_verdict[1:0];
              rec_value   = in_value;
            end
          endcase
        end
      end
      strs_pkg::CMD_ABORT: begin
        if (!running) begin
          res_status_next = strs_pkg::ST_NOT_RUNNING;
        end else begin
          running_next    = 1'b0;
          r0_kind_next    = strs_pkg::EV_ABORT;
          r0_step_next    = step_index;
          r0_verdict_next = strs_pkg::V_ERROR;
          r0_value_next   = 32'(failure_count);
        end
      end
      default: begin
      end
    endcase

    if (rec) begin
      if (strs_pkg::rank(rec_verdict) > strs_pkg::rank(worst_verdict)) begin
        worst_verdict_next = rec_verdict;
      end
      if (rec_verdict == strs_pkg::V_FAIL || rec_verdict == strs_pkg::V_ERROR) begin
        failure_count_next = failure_count + 4'd1;
      end
      r0_kind_next         = strs_pkg::EV_PROGRESS;
      r0_step_next         = step_index;
      r0_verdict_next      = rec_verdict;
      r0_value_next        = rec_value;
      step_index_next      = step_index + strs_pkg::STEP_W'(1);
      step_start_time_next = in_now;
      if (in_done || step_index_next >= step_total) begin
        running_next    = 1'b0;
        res_status_next = strs_pkg::ST_COMPLETE;
        two_next        = 1'b1;
        r1_step_next    = step_index_next;
        r1_verdict_next = worst_verdict_next;
        r1_value_next   = 32'(failure_count_next);
      end else begin
        res_status_next = strs_pkg::ST_ADVANCED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      current_test    <= '0;
      step_index      <= '0;
      step_total      <= '0;
      worst_verdict   <= strs_pkg::V_PASS;
      failure_count   <= '0;
      session_of_run  <= '0;
      step_start_time <= '0;
      current_run_id  <= '0;
      next_run_number <= 32'd1;
      two             <= 1'b0;
    end else if (ctl.exec) begin
      running         <= running_next;
      current_test    <= current_test_next;
      step_index      <= step_index_next;
      step_total      <= step_total_next;
      worst_verdict   <= worst_verdict_next;
      failure_count   <= failure_count_next;
      session_of_run  <= session_of_run_next;
      step_start_time <= step_start_time_next;
      current_run_id  <= current_run_id_next;
      next_run_number <= next_run_number_next;
      two             <= two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= res_status_next;
      r0_kind    <= r0_kind_next;
      r0_step    <= r0_step_next;
      r0_verdict <= r0_verdict_next;
      r0_value   <= r0_value_next;
      r1_step    <= r1_step_next;
      r1_verdict <= r1_verdict_next;
      r1_value   <= r1_value_next;
    end
  end

  assign dividend = strs_pkg::PROD_W'(step_index) * strs_pkg::PROD_W'(strs_pkg::PERMILLE_SCALE);

  strs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (step_total),
    .quotient (quotient),
    .busy     (div_busy)
  );

  assign stat.two_results = two;
  assign stat.div_busy    = div_busy;

  // second result is always the run result
  assign status            = res_status;
  assign event_kind        = ctl.sel_second ? strs_pkg::EV_RESULT : r0_kind;
  assign event_test        = (event_kind != strs_pkg::EV_NONE) ? current_test : '0;
  assign event_step        = ctl.sel_second ? r1_step : r0_step;
  assign event_verdict     = ctl.sel_second ? r1_verdict : r0_verdict;
  assign event_value       = ctl.sel_second ? r1_value : r0_value;
  assign run_id            = current_run_id;
  assign busy_res          = running;
  assign progress_permille = (running && step_total != '0) ? quotient : '0;

endmodule

[rtl/strs_ctrl.sv]
// controller state machine: request intake, evaluation, divide wait, result delivery
// depends on strs_pkg
module strs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  output strs_pkg::dp_cmd_t    ctl,
  input  strs_pkg::dp_status_t stat
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_DSTART = 6'b000100,
    S_DWAIT  = 6'b001000,
    S_OUT0   = 6'b010000,
    S_OUT1   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_DSTART;
      end
      S_DSTART: begin
        ctl.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = S_OUT0;
        end
      end
      S_OUT0: begin
        out_valid = 1'b1;
        out_last  = !stat.two_results;
        if (out_ready) begin
          state_next = stat.two_results ? S_OUT1 : S_IDLE;
        end
      end
      S_OUT1: begin
        out_valid      = 1'b1;
        out_last       = 1'b1;
        ctl.sel_second = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/self_test_run_sequencer_unit.sv]
// top level of the self-test run sequencer: stream ports, field packing
// depends on strs_pkg, strs_ctrl and strs_datapath
//
// usage:
//   requests enter on the s_axis group; s_axis_tuser carries the command
//   (start, step, abort, query) and s_axis_tdata the remaining fields.
//   each request gives one result, or two when a step completes the run
//   (progress event first, then the run result with tlast set).
//   results leave on the m_axis group with the event kind in m_axis_tuser.
//   one request is handled at a time: s_axis_tready is high only while
//   idle. after acceptance the request is evaluated, the divider is
//   loaded, the 14-bit serial permille divide runs, the divider done
//   check follows and the output stage presents the results; most of
//   a request's time is spent in the serial divider.
//   if the receiver holds m_axis_tready low the result stays put and no
//   new request is taken until every result has been delivered.
//   reset clears the run state: no run active, next run id 1.
module self_test_run_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // test_id[7:0], session_id[39:8], now_ms[71:40], action_outcome[73:72],
  // action_verdict[81:74], action_value[113:82], action_done[114], zero fill
  input  logic [strs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[2:0], event_test[6:3], event_step[10:7], event_verdict[12:11],
  // event_value[44:13], run_id[76:45], busy_res[77], progress_permille[87:78]
  output logic [strs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,
  // event_kind[2:0]
  output logic [2:0]                         m_axis_tuser
);

  strs_pkg::dp_cmd_t    ctl;
  strs_pkg::dp_status_t stat;

  logic [2:0]         status;
  logic [2:0]         event_kind;
  logic [3:0]         event_test;
  logic [3:0]         event_step;
  logic [1:0]         event_verdict;
  logic signed [31:0] event_value;
  logic [31:0]        run_id;
  logic               busy_res;
  logic [9:0]         progress_permille;

  strs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .ctl       (ctl),
    .stat      (stat)
  );

  strs_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cmd               (s_axis_tuser),
    .test_id           (s_axis_tdata[7:0]),
    .session_id        (s_axis_tdata[39:8]),
    .now_ms            (s_axis_tdata[71:40]),
    .action_outcome    (s_axis_tdata[73:72]),
    .action_verdict    (s_axis_tdata[81:74]),
    .action_value      (s_axis_tdata[113:82]),
    .action_done       (s_axis_tdata[114]),
    .status            (status),
    .event_kind        (event_kind),
    .event_test        (event_test),
    .event_step        (event_step),
    .event_verdict     (event_verdict),
    .event_value       (event_value),
    .run_id            (run_id),
    .busy_res          (busy_res),
    .progress_permille (progress_permille)
  );

  assign m_axis_tdata = {progress_permille, busy_res, run_id, event_value,
                         event_verdict, event_step, event_test, status};
  assign m_axis_tuser = event_kind;

endmodule

[rtl/strs_checker.sv]
// port-level checks for the run sequencer, bound to the top level
// depends on strs_pkg and assert_macros.svh
`include "assert_macros.svh"

module strs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [strs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic [2:0]                       m_axis_tuser
);

  // held result must not change while stalled
  `STRS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result changed while stalled")

  // one request in flight: intake closes right after a request
  `STRS_ASSERT_NEXT(a_one_request, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

  `STRS_ASSERT(a_no_overlap, clk, rst, !(s_axis_tready && m_axis_tvalid), "intake open while a result is pending")

  // progress is zero when idle, below full scale with a valid run id when busy
  `STRS_ASSERT(a_progress, clk, rst, m_axis_tvalid |-> (m_axis_tdata[77] ? (m_axis_tdata[76:45] != 32'd0 && m_axis_tdata[87:78] < 10'd1000) : (m_axis_tdata[87:78] == 10'd0)), "progress or run id inconsistent with busy")

  // a run result closes the request and leaves the block idle
  `STRS_ASSERT(a_result_last, clk, rst, (m_axis_tvalid && m_axis_tuser == strs_pkg::EV_RESULT) |-> (m_axis_tlast && !m_axis_tdata[77]), "run result not final or still busy")

endmodule

bind self_test_run_sequencer_unit strs_checker u_strs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
